FILE: src/ppmfd_pkg.sv
// shared types and constants of the ppm frame decoder
package ppmfd_pkg;

    localparam int AXIS_CHANNELS = 4;
    localparam int CH_W          = 2;
    localparam int US_W          = 16;
    localparam int AXIS_W        = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int DIV_CNT_W     = $clog2(AXIS_W);

    typedef logic [US_W-1:0]      t_us;
    typedef logic [AXIS_W-1:0]    t_axis;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CH_W-1:0]      t_ch;

    // register indexes of the configuration port
    localparam t_cfg_idx CFG_CALIBRATE  = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_BUTTON_THR = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_SYNC_MIN   = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_SYNC_MAX   = t_cfg_idx'(3);
    localparam t_cfg_idx CFG_CAL_STEP   = t_cfg_idx'(4);
    localparam t_cfg_idx CFG_JITTER     = t_cfg_idx'(5);

    // reset values
    localparam logic RST_CALIBRATE  = 1'b1;
    localparam t_us  RST_BUTTON_THR = t_us'(1500);
    localparam t_us  RST_SYNC_MIN   = t_us'(5000);
    localparam t_us  RST_SYNC_MAX   = t_us'(20000);
    localparam t_us  RST_CAL_STEP   = t_us'(200);
    localparam t_us  RST_JITTER     = t_us'(20);
    localparam t_us  RST_BOUND      = t_us'(1500);

    localparam t_axis AXIS_FULL = t_axis'(255);

endpackage

FILE: src/ppmfd_ifs.sv
// handshake channels of the ppm frame decoder: interval in, frame out, config writes
interface ppmfd_in_if import ppmfd_pkg::*; ();
    logic valid;
    logic ready;
    t_us  interval_us;

    modport source (output valid, output interval_us, input ready);
    modport sink   (input valid, input interval_us, output ready);
endinterface

interface ppmfd_out_if import ppmfd_pkg::*; ();
    logic  valid;
    logic  ready;
    t_axis axis_x;
    t_axis axis_y;
    t_axis axis_rx;
    t_axis axis_ry;
    logic  button_a;
    logic  button_b;

    modport source (output valid, output axis_x, output axis_y, output axis_rx,
                    output axis_ry, output button_a, output button_b, input ready);
    modport sink   (input valid, input axis_x, input axis_y, input axis_rx,
                    input axis_ry, input button_a, input button_b, output ready);
endinterface

interface ppmfd_cfg_if import ppmfd_pkg::*; ();
    logic     valid;
    logic     ready;
    t_cfg_idx idx;
    t_us      data;

    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface

FILE: src/ppm_frame_decoder_calibrated.sv
// ppm frame decoder with per-channel calibration, jitter filter and 0..255 scaling
// an interval that does not close a frame is stored while idle, and ready stays high
// a frame-closing interval runs a check, then 4 calibration steps if calibration is on,
//   per axis a setup, and in range a load and 8 steps of the shared restoring divider
// one frame result per good frame, held in an output register until its beat is taken
// reset (synchronous, active low) restores registers, bounds, frame store and axes

module ppm_frame_decoder_calibrated import ppmfd_pkg::*; #(
    parameter int FRAME_SLOTS = 7
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ppmfd_in_if.sink     i_in,
    ppmfd_out_if.source  o_out,
    ppmfd_cfg_if.sink    i_cfg
);

    localparam int SLOT_W = $clog2(FRAME_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(FRAME_SLOTS - 1);
    localparam logic [SLOT_W-1:0] BTN_A_SLOT = SLOT_W'(AXIS_CHANNELS + 1);
    localparam logic [SLOT_W-1:0] BTN_B_SLOT = SLOT_W'(AXIS_CHANNELS + 2);
    localparam t_ch LAST_CH = t_ch'(AXIS_CHANNELS - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(AXIS_W - 1);

    // which channel feeds which output axis
    localparam t_ch CH_Y  = t_ch'(0);
    localparam t_ch CH_RY = t_ch'(1);
    localparam t_ch CH_RX = t_ch'(2);
    localparam t_ch CH_X  = t_ch'(3);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CAL,
        ST_SETUP,
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } t_state;

    t_state r_state;

    // configuration registers
    logic r_calibrate;
    t_us  r_button_thr;
    t_us  r_sync_min;
    t_us  r_sync_max;
    t_us  r_cal_step;
    t_us  r_jitter;

    // frame and channel state
    logic [SLOT_W-1:0] r_slot;
    t_us               r_store [FRAME_SLOTS];
    t_us               r_min   [AXIS_CHANNELS];
    t_us               r_max   [AXIS_CHANNELS];
    t_us               r_prev  [AXIS_CHANNELS];
    t_axis             r_axis  [AXIS_CHANNELS];
    logic              r_resync;

    // sequencer and shared divider
    t_ch                  r_ch;
    t_us                  r_diff;
    t_us                  r_span;
    t_us                  r_rem;
    logic [AXIS_W-1:0]    r_nlo;
    logic [AXIS_W-1:0]    r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;

    // output register
    logic  r_out_valid;
    t_axis r_out_x;
    t_axis r_out_y;
    t_axis r_out_rx;
    t_axis r_out_ry;
    logic  r_out_a;
    logic  r_out_b;

    logic [SLOT_W-1:0]    n_slot;
    logic                 w_accept;
    logic                 w_sync_hit;
    t_us                  w_pulse;
    t_us                  w_lo;
    t_us                  w_hi;
    t_us                  w_gap;
    logic [US_W+AXIS_W-1:0] w_num;
    logic [US_W:0]        w_trial;
    logic                 w_fit;
    t_us                  w_rem_next;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = (r_state == ST_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;

    always_comb begin
        // slot ring advances before the interval is written
        n_slot     = (r_slot == LAST_SLOT) ? '0 : r_slot + SLOT_W'(1);
        // sync pause seen while resyncing: true open range test
        w_sync_hit = r_resync && (i_in.interval_us > r_sync_min)
                     && (i_in.interval_us < r_sync_max);

        // channel c lives in slot c+1
        w_pulse = r_store[SLOT_W'(r_ch) + SLOT_W'(1)];
        w_lo    = r_min[r_ch];
        w_hi    = r_max[r_ch];
        w_gap   = (r_prev[r_ch] > w_pulse) ? r_prev[r_ch] - w_pulse : w_pulse - r_prev[r_ch];

        // numerator diff*255 as diff*256 - diff
        w_num = {r_diff, {AXIS_W{1'b0}}} - {{AXIS_W{1'b0}}, r_diff};

        // one restoring division step
        w_trial    = {r_rem, r_nlo[AXIS_W-1]};
        w_fit      = (w_trial >= {1'b0, r_span});
        w_rem_next = w_fit ? US_W'(w_trial - {1'b0, r_span}) : w_trial[US_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_calibrate  <= RST_CALIBRATE;
            r_button_thr <= RST_BUTTON_THR;
            r_sync_min   <= RST_SYNC_MIN;
            r_sync_max   <= RST_SYNC_MAX;
            r_cal_step   <= RST_CAL_STEP;
            r_jitter     <= RST_JITTER;
            r_slot       <= '0;
            r_resync     <= 1'b0;
            r_ch         <= '0;
            r_out_valid  <= 1'b0;
            for (int k = 0; k < FRAME_SLOTS; k++) begin
                r_store[k] <= '0;
            end
            for (int k = 0; k < AXIS_CHANNELS; k++) begin
                r_min[k]  <= RST_BOUND;
                r_max[k]  <= RST_BOUND;
                r_prev[k] <= '0;
                r_axis[k] <= '0;
            end
        end else begin
            // config beats land only while idle
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.idx)
                    CFG_CALIBRATE:  r_calibrate  <= i_cfg.data[0];
                    CFG_BUTTON_THR: r_button_thr <= i_cfg.data;
                    CFG_SYNC_MIN:   r_sync_min   <= i_cfg.data;
                    CFG_SYNC_MAX:   r_sync_max   <= i_cfg.data;
                    CFG_CAL_STEP:   r_cal_step   <= i_cfg.data;
                    CFG_JITTER:     r_jitter     <= i_cfg.data;
                    default: ;
                endcase
            end

            // result beat taken downstream, emit reloads it itself
            if (r_out_valid && o_out.ready && r_state != ST_EMIT) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_store[n_slot] <= i_in.interval_us;
                        if (w_sync_hit) begin
                            // sync pause realigns the frame to slot 0
                            if (n_slot != '0) begin
                                r_store[0] <= i_in.interval_us;
                            end
                            r_slot     <= '0;
                            r_resync   <= 1'b0;
                        end else begin
                            r_slot <= n_slot;
                        end
                        // frame flag is taken before the resync move
                        if (n_slot == LAST_SLOT) begin
                            r_state <= ST_CHECK;
                        end
                    end
                end

                ST_CHECK: begin
                    r_ch <= '0;
                    if (r_store[0] < r_sync_min) begin
                        // slot 0 is no sync pause: drop the frame and hunt
                        r_resync <= 1'b1;
                        r_state  <= ST_IDLE;
                    end else if (r_calibrate) begin
                        r_state <= ST_CAL;
                    end else begin
                        r_state <= ST_SETUP;
                    end
                end

                ST_CAL: begin
                    // widen bounds only by less than one calibration step
                    if (w_pulse < w_lo && (w_lo - w_pulse) < r_cal_step) begin
                        r_min[r_ch] <= w_pulse;
                    end
                    if (w_pulse > w_hi && (w_pulse - w_hi) < r_cal_step) begin
                        r_max[r_ch] <= w_pulse;
                    end
                    if (r_ch == LAST_CH) begin
                        r_ch    <= '0;
                        r_state <= ST_SETUP;
                    end else begin
                        r_ch <= r_ch + t_ch'(1);
                    end
                end

                ST_SETUP: begin
                    r_prev[r_ch] <= w_pulse;
                    r_diff       <= w_pulse - w_lo;
                    r_span       <= w_hi - w_lo;
                    if (w_gap < r_jitter && w_hi > w_lo && w_pulse > w_lo
                        && w_pulse < w_hi) begin
                        // in range: go through the divider
                        r_state <= ST_LOAD;
                    end else begin
                        if (w_gap < r_jitter) begin
                            // empty span or at/below min reads 0, at/above max reads full
                            r_axis[r_ch] <= (w_hi > w_lo && w_pulse >= w_hi) ? AXIS_FULL : '0;
                        end
                        if (r_ch == LAST_CH) begin
                            r_state <= ST_EMIT;
                        end else begin
                            r_ch <= r_ch + t_ch'(1);
                        end
                    end
                end

                ST_LOAD: begin
                    // upper part is already below the span since quotient fits in a byte
                    r_rem   <= w_num[US_W+AXIS_W-1:AXIS_W];
                    r_nlo   <= w_num[AXIS_W-1:0];
                    r_cnt   <= DIV_LAST;
                    r_state <= ST_DIV;
                end

                ST_DIV: begin
                    r_rem <= w_rem_next;
                    r_nlo <= {r_nlo[AXIS_W-2:0], 1'b0};
                    r_quo <= {r_quo[AXIS_W-2:0], w_fit};
                    if (r_cnt == '0) begin
                        r_axis[r_ch] <= {r_quo[AXIS_W-2:0], w_fit};
                        if (r_ch == LAST_CH) begin
                            r_state <= ST_EMIT;
                        end else begin
                            r_ch    <= r_ch + t_ch'(1);
                            r_state <= ST_SETUP;
                        end
                    end else begin
                        r_cnt <= r_cnt - DIV_CNT_W'(1);
                    end
                end

                ST_EMIT: begin
                    // wait for the output register to free up
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_x     <= r_axis[CH_X];
                        r_out_y     <= r_axis[CH_Y];
                        r_out_rx    <= r_axis[CH_RX];
                        r_out_ry    <= r_axis[CH_RY];
                        r_out_a     <= !(r_store[BTN_A_SLOT] > r_button_thr);
                        r_out_b     <= !(r_store[BTN_B_SLOT] > r_button_thr);
                        r_state     <= ST_IDLE;
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.axis_x   = r_out_x;
    assign o_out.axis_y   = r_out_y;
    assign o_out.axis_rx  = r_out_rx;
    assign o_out.axis_ry  = r_out_ry;
    assign o_out.button_a = r_out_a;
    assign o_out.button_b = r_out_b;

endmodule

FILE: verif/ppm_frame_decoder_calibrated_tb.sv
// self-checking testbench of the calibrated ppm frame decoder, random ppm frames vs a predictor
module ppm_frame_decoder_calibrated_tb;
    import ppmfd_pkg::*;

    localparam int       FRAME_SLOTS    = 7;
    localparam int       LAST_SLOT      = FRAME_SLOTS - 1;
    localparam int       SETTLE_CYCLES  = 64;
    localparam int       LONG_HOLD      = 400;
    localparam int       TIMEOUT_CYCLES = 1_000_000;
    localparam int       REPORT_LIMIT   = 10;
    localparam t_cfg_idx CFG_SPARE_LO   = t_cfg_idx'(6);
    localparam t_cfg_idx CFG_SPARE_HI   = t_cfg_idx'(7);

    typedef struct packed {
        t_axis axis_x;
        t_axis axis_y;
        t_axis axis_rx;
        t_axis axis_ry;
        logic  button_a;
        logic  button_b;
    } frame_beat_t;

    // frame predictor plus queue of frame beats still owed by the decoder
    class frame_scoreboard;
        bit          calibrate;
        t_us         button_thr;
        t_us         sync_min;
        t_us         sync_max;
        t_us         cal_step;
        t_us         jitter_lim;
        int unsigned slot;
        t_us         frame_store [FRAME_SLOTS];
        t_us         ch_lo       [AXIS_CHANNELS];
        t_us         ch_hi       [AXIS_CHANNELS];
        t_us         last_pulse  [AXIS_CHANNELS];
        t_axis       axis_hold   [AXIS_CHANNELS];
        bit          resync_wait;
        frame_beat_t expected_frames[$];
        int unsigned mismatches;

        function new();
            calibrate   = RST_CALIBRATE;
            button_thr  = RST_BUTTON_THR;
            sync_min    = RST_SYNC_MIN;
            sync_max    = RST_SYNC_MAX;
            cal_step    = RST_CAL_STEP;
            jitter_lim  = RST_JITTER;
            slot        = 0;
            resync_wait = 1'b0;
            mismatches  = 0;
            foreach (frame_store[k]) frame_store[k] = '0;
            foreach (ch_lo[k]) begin
                ch_lo[k]      = RST_BOUND;
                ch_hi[k]      = RST_BOUND;
                last_pulse[k] = '0;
                axis_hold[k]  = '0;
            end
        endfunction

        function void write_reg(t_cfg_idx idx, t_us data);
            case (idx)
                CFG_CALIBRATE:  calibrate  = data[0];
                CFG_BUTTON_THR: button_thr = data;
                CFG_SYNC_MIN:   sync_min   = data;
                CFG_SYNC_MAX:   sync_max   = data;
                CFG_CAL_STEP:   cal_step   = data;
                CFG_JITTER:     jitter_lim = data;
                default: ;
            endcase
        endfunction

        function int unsigned pulse_gap(t_us a, t_us b);
            return (a > b) ? a - b : b - a;
        endfunction

        function t_axis scale_pulse(t_us p, t_us lo, t_us hi);
            int unsigned num;
            int unsigned span;
            if (hi <= lo || p <= lo) return '0;
            if (p >= hi) return AXIS_FULL;
            num  = p - lo;
            span = hi - lo;
            return t_axis'((num * AXIS_FULL) / span);
        endfunction

        function void take_interval(t_us v);
            bit          frame_done;
            t_us         p;
            frame_beat_t beat;
            slot = (slot == LAST_SLOT) ? 0 : slot + 1;
            frame_store[slot] = v;
            frame_done = (slot == LAST_SLOT);
            // pending resync grabs the first interval that looks like a sync pause
            if (resync_wait && v > sync_min && v < sync_max) begin
                frame_store[0] = v;
                slot           = 0;
                resync_wait    = 1'b0;
            end
            if (!frame_done) return;
            if (frame_store[0] < sync_min) begin
                resync_wait = 1'b1;
                return;
            end
            if (calibrate) begin
                for (int c = 0; c < AXIS_CHANNELS; c++) begin
                    p = frame_store[c + 1];
                    if (p < ch_lo[c] && pulse_gap(p, ch_lo[c]) < cal_step) ch_lo[c] = p;
                    if (p > ch_hi[c] && pulse_gap(p, ch_hi[c]) < cal_step) ch_hi[c] = p;
                end
            end
            // jitter filter, previous pulses move on whether or not the axis did
            for (int c = 0; c < AXIS_CHANNELS; c++) begin
                p = frame_store[c + 1];
                if (pulse_gap(last_pulse[c], p) < jitter_lim)
                    axis_hold[c] = scale_pulse(p, ch_lo[c], ch_hi[c]);
            end
            for (int c = 0; c < AXIS_CHANNELS; c++) last_pulse[c] = frame_store[c + 1];
            beat.axis_x   = axis_hold[3];
            beat.axis_y   = axis_hold[0];
            beat.axis_rx  = axis_hold[2];
            beat.axis_ry  = axis_hold[1];
            beat.button_a = (frame_store[AXIS_CHANNELS + 1] <= button_thr);
            beat.button_b = (frame_store[AXIS_CHANNELS + 2] <= button_thr);
            expected_frames.push_back(beat);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) $display("mismatch at %0t: %s", $time, msg);
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) flag($sformatf("%s expected %0d got %0d", name, want, got));
        endfunction

        function void take_frame(frame_beat_t got);
            frame_beat_t want;
            if (expected_frames.size() == 0) begin
                flag($sformatf("frame beat %h with none pending", got));
                return;
            end
            want = expected_frames.pop_front();
            check_field("axis_x",   want.axis_x,   got.axis_x);
            check_field("axis_y",   want.axis_y,   got.axis_y);
            check_field("axis_rx",  want.axis_rx,  got.axis_rx);
            check_field("axis_ry",  want.axis_ry,  got.axis_ry);
            check_field("button_a", want.button_a, got.button_a);
            check_field("button_b", want.button_b, got.button_b);
        endfunction
    endclass

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    frame_scoreboard sb;
    bit              gaps_on       = 1'b1;
    bit              long_hold_req = 1'b0;
    int unsigned     items_sent    = 0;
    int              pulse_walk [AXIS_CHANNELS];

    // extremes of the field, an out-of-sync frame, a resync landing on the
    // closing slot, then an aligned frame around the reset bounds
    t_us directed_run [19] = '{16'hFFFF, 16'h0000, 16'h0001, 16'h8000, 16'h5555, 16'hAAAA,
                               16'd5000, 16'd20000, 16'd100, 16'd100, 16'd100, 16'd100,
                               16'd6000, 16'd1500, 16'd1500, 16'd1520, 16'd1480, 16'd1500,
                               16'd1501};

    ppmfd_in_if  in_ch  ();
    ppmfd_out_if out_ch ();
    ppmfd_cfg_if cfg_ch ();

    ppm_frame_decoder_calibrated i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    // frame beat monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sb.take_frame(frame_beat_t'{out_ch.axis_x, out_ch.axis_y, out_ch.axis_rx,
                                        out_ch.axis_ry, out_ch.button_a, out_ch.button_b});
        end
    end

    // frame beat receiver: random stall bursts, one long hold on request
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    task automatic send_interval(t_us v);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.interval_us <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.take_interval(v);
        items_sent++;
    endtask

    task automatic write_register(t_cfg_idx idx, t_us data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.idx   <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_frames_out();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_frames.size() != 0) @(posedge i_clk);
    endtask

    // registers only change once the decoder has gone quiet
    task automatic set_registers(t_us cal, t_us thr, t_us smin, t_us smax, t_us cstep,
                                 t_us jit);
        wait_frames_out();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_register(CFG_CALIBRATE,  cal);
        write_register(CFG_BUTTON_THR, thr);
        write_register(CFG_SYNC_MIN,   smin);
        write_register(CFG_SYNC_MAX,   smax);
        write_register(CFG_CAL_STEP,   cstep);
        write_register(CFG_JITTER,     jit);
    endtask

    function automatic t_us pick_sync();
        if (int'(sb.sync_max) - int'(sb.sync_min) >= 2)
            return t_us'($urandom_range(sb.sync_min + 1, sb.sync_max - 1));
        return t_us'($urandom_range(sb.sync_min, 16'hFFFF));
    endfunction

    // stick channels drift slowly so bounds widen and the jitter filter passes
    function automatic t_us next_pulse(int c);
        int drift;
        if ($urandom_range(0, 19) == 0) return t_us'($urandom_range(0, 16'hFFFF));
        drift = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 60)) - 30;
        pulse_walk[c] += drift;
        if (pulse_walk[c] < 800)  pulse_walk[c] = 800;
        if (pulse_walk[c] > 2200) pulse_walk[c] = 2200;
        return t_us'(pulse_walk[c]);
    endfunction

    function automatic t_us button_pulse();
        case ($urandom_range(0, 3))
            0:       return t_us'($urandom_range(0, 16'hFFFF));
            1:       return sb.button_thr;
            2:       return t_us'(sb.button_thr + 1);
            default: return t_us'($urandom_range(900, 2100));
        endcase
    endfunction

    task automatic run_phase(int unsigned n_items);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                // well-formed frame: sync pause, four sticks, two buttons
                send_interval(pick_sync());
                for (int c = 0; c < AXIS_CHANNELS; c++) send_interval(next_pulse(c));
                send_interval(button_pulse());
                send_interval(button_pulse());
            end else if (pick < 88) begin
                // truncated frame knocks the decoder out of step
                send_interval(pick_sync());
                repeat ($urandom_range(0, 5)) send_interval(next_pulse($urandom_range(0, 3)));
            end else begin
                repeat ($urandom_range(1, 8)) send_interval(t_us'($urandom_range(0, 16'hFFFF)));
            end
        end
    endtask

    initial begin
        sb = new();
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.interval_us <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.idx        <= CFG_CALIBRATE;
        cfg_ch.data       <= '0;
        foreach (pulse_walk[c]) pulse_walk[c] = 1500;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_run[k]) send_interval(directed_run[k]);

        // reset settings, then a long receiver hold while frames keep coming
        run_phase(100);
        long_hold_req = 1'b1;
        run_phase(60);

        // everything passes: no calibration, no filter, any pause is a sync
        set_registers(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(40);
        wait_frames_out();
        run_phase(40);

        // unlimited widening, every button released only above full scale
        set_registers(16'h0001, 16'hFFFF, 16'd3000, 16'd30000, 16'hFFFF, 16'hFFFF);
        run_phase(80);

        // sync needs an all-ones pause; calibrate takes bit 0 only, spare indexes do nothing
        set_registers(16'hFFFE, 16'd1500, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        write_register(CFG_SPARE_LO, 16'hFFFF);
        write_register(CFG_SPARE_HI, 16'h1234);
        run_phase(40);

        // nominal receiver settings, no idling on either side
        gaps_on = 1'b0;
        set_registers(16'h0001, 16'd1500, 16'd5000, 16'd20000, 16'd200, 16'd20);
        run_phase(80);
        gaps_on = 1'b1;

        repeat (4) begin
            set_registers(t_us'($urandom_range(0, 1)), t_us'($urandom_range(900, 2100)),
                          t_us'($urandom_range(1000, 6000)), t_us'($urandom_range(8000, 65535)),
                          t_us'($urandom_range(0, 400)), t_us'($urandom_range(0, 60)));
            run_phase(60);
        end

        // closing stretch at full rate
        gaps_on = 1'b0;
        set_registers(16'h0001, 16'd1500, 16'd5000, 16'd20000, 16'd200, 16'd20);
        run_phase(60);

        wait_frames_out();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("ppm_frame_decoder_calibrated_tb: clean");
        end else begin
            $display("ppm_frame_decoder_calibrated_tb: errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("ppm_frame_decoder_calibrated_tb: errors");
        $finish;
    end

endmodule

FILE: filelist.f
src/ppmfd_pkg.sv
src/ppmfd_ifs.sv
src/ppm_frame_decoder_calibrated.sv
verif/ppm_frame_decoder_calibrated_tb.sv
